/* rtl/jbs3_pkg.sv */
// Shared types, constants and fixed-point helpers of the bulb iteration core.
`timescale 1ns / 1ps
package jbs3_pkg;

   localparam int CoordWidth = 32;
   localparam int FracBits   = 20;
   localparam int DeWidth    = 48;
   localparam int RadWidth   = CoordWidth - 1;

   localparam int DIV_LAT  = 33;
   localparam int SQRT_LAT = 36;
   localparam int LATENCY  = 24 + 3 * DIV_LAT + 5 * SQRT_LAT;

   typedef logic signed [CoordWidth-1:0] fix_type;

   localparam fix_type FIX_MAX = {1'b0, {(CoordWidth-1){1'b1}}};
   localparam fix_type FIX_MIN = {1'b1, {(CoordWidth-1){1'b0}}};
   localparam fix_type FIX_ONE = fix_type'(64'd1 << FracBits);
   localparam fix_type FIX_HALF_SQRT2 = 32'h000B504F;
   localparam logic [31:0] TAN_PI8_Q32 = 32'h6A09E668;
   localparam logic [DeWidth-1:0] DE_MAX = {DeWidth{1'b1}};

   localparam logic [2:0] REG_CROSS_SCALE = 3'd0;
   localparam logic [2:0] REG_Y_SCALE     = 3'd1;
   localparam logic [2:0] REG_POST_SCALE  = 3'd2;
   localparam logic [2:0] REG_SPHERE_OFF  = 3'd3;
   localparam logic [2:0] REG_MODE        = 3'd4;
   localparam logic [2:0] REG_FOLD_WINDOW = 3'd5;
   localparam logic [2:0] REG_ADD_CONST   = 3'd6;
   localparam logic [2:0] REG_PIXEL_MULT  = 3'd7;

   localparam int MODE_PIXEL    = 0;
   localparam int MODE_ABS_X    = 1;
   localparam int MODE_ABS_Y    = 2;
   localparam int MODE_ABS_Z    = 3;
   localparam int MODE_FOLD     = 4;
   localparam int MODE_ANALYTIC = 5;

   typedef struct packed {
      fix_type x;
      fix_type y;
      fix_type z;
      fix_type w;
      fix_type cx;
      fix_type cy;
      fix_type cz;
      logic [DeWidth-1:0] de;
      logic [RadWidth-1:0] rad;
      logic [7:0] it;
      logic [2:0] sec;
      logic fold;
      fix_type a;
      fix_type b;
      fix_type c;
      fix_type d;
      fix_type e;
      fix_type f;
      logic [63:0] pa;
      logic [63:0] pb;
      logic [55:0] dh;
      logic [55:0] dl;
   } item_type;

   function automatic logic [31:0] mag(fix_type a);
      return a[31] ? 32'(-a) : 32'(a);
   endfunction

   function automatic fix_type from_mag(logic neg, logic [63:0] m);
      if (neg) begin
         return (m > 64'h8000_0000) ? FIX_MIN : fix_type'(-m[31:0]);
      end
      return (m > 64'(FIX_MAX)) ? FIX_MAX : fix_type'(m[31:0]);
   endfunction

   function automatic fix_type sat_add(fix_type a, fix_type b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) return s[32] ? FIX_MIN : FIX_MAX;
      return fix_type'(s[31:0]);
   endfunction

   function automatic fix_type sat_sub(fix_type a, fix_type b);
      logic [32:0] s;
      s = {a[31], a} - {b[31], b};
      if (s[32] != s[31]) return s[32] ? FIX_MIN : FIX_MAX;
      return fix_type'(s[31:0]);
   endfunction

   function automatic fix_type sat_dbl(fix_type a);
      return sat_add(a, a);
   endfunction

   function automatic fix_type abs_sat(fix_type a);
      if (a == FIX_MIN) return FIX_MAX;
      return a[31] ? -a : a;
   endfunction

   function automatic fix_type fmul(fix_type a, fix_type b);
      logic [63:0] p;
      p = 64'(mag(a)) * 64'(mag(b)) + (64'd1 << (FracBits - 1));
      return from_mag(a[31] != b[31], p >> FracBits);
   endfunction

   function automatic fix_type q16_to_fix(logic [20:0] v);
      return fix_type'({{7{v[20]}}, v, 4'b0000});
   endfunction

   function automatic fix_type cos_of(logic [2:0] sec);
      fix_type r;
      case (sec)
         3'd0: r = FIX_ONE;
         3'd1: r = FIX_HALF_SQRT2;
         3'd3: r = -FIX_HALF_SQRT2;
         3'd4: r = -FIX_ONE;
         3'd5: r = -FIX_HALF_SQRT2;
         3'd7: r = FIX_HALF_SQRT2;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic fix_type sin_of(logic [2:0] sec);
      fix_type r;
      case (sec)
         3'd1: r = -FIX_HALF_SQRT2;
         3'd2: r = -FIX_ONE;
         3'd3: r = -FIX_HALF_SQRT2;
         3'd5: r = FIX_HALF_SQRT2;
         3'd6: r = FIX_ONE;
         3'd7: r = FIX_HALF_SQRT2;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] sector_of(fix_type y, fix_type z, logic [63:0] pa,
                                            logic [63:0] pb);
      logic [2:0] r;
      if (y == 0 && z == 0) r = 3'd0;
      else if ({mag(z), 32'h0} <= pa) r = (y > 0) ? 3'd0 : 3'd4;
      else if ({mag(y), 32'h0} <= pb) r = (z > 0) ? 3'd2 : 3'd6;
      else if (y > 0) r = (z > 0) ? 3'd1 : 3'd7;
      else r = (z > 0) ? 3'd3 : 3'd5;
      return r;
   endfunction

   function automatic logic [DeWidth-1:0] de_fin(logic [55:0] ph, logic [55:0] pl, int sh);
      logic [80:0] s;
      s = (81'(ph) << 24) + 81'(pl) + (81'd1 << (sh - 1));
      s = s >> sh;
      if (|s[80:DeWidth]) return DE_MAX;
      return s[DeWidth-1:0];
   endfunction

   function automatic fix_type sign_offset(fix_type coord, fix_type t);
      if (coord > 0) return t;
      if (coord < 0) return sat_sub('0, t);
      return '0;
   endfunction

endpackage

/* rtl/jbs3_delay.sv */
// Shift line that carries an item and its valid bit alongside a long unit.
`timescale 1ns / 1ps
module jbs3_delay #(
   parameter int W = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   output logic [W-1:0] out_data
);
   logic [W-1:0] line_ff [0:DEPTH-1];
   logic [DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
      line_ff[0] <= in_data;
      for (int k = 1; k < DEPTH; k++) begin
         line_ff[k] <= line_ff[k-1];
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = line_ff[DEPTH-1];
endmodule

/* rtl/jbs3_div.sv */
// Pipelined fixed-point divider, one quotient bit per stage, saturating.
`timescale 1ns / 1ps
module jbs3_div import jbs3_pkg::*; (
   input  logic    clock,
   input  fix_type num,
   input  fix_type den,
   output fix_type quo
);
   logic [31:0] ub_ff   [0:31];
   logic [30:0] nlow_ff [0:31];
   logic [31:0] rem_ff  [0:31];
   logic [30:0] q_ff    [0:31];
   logic        neg_ff  [0:31];
   logic        big_ff  [0:31];
   fix_type     quo_ff;
   logic [31:0] ua_in;
   logic [31:0] ub_in;

   always_comb begin
      ua_in = mag(num);
      ub_in = (den == 0) ? 32'd1 : mag(den);
   end

   always_ff @(posedge clock) begin
      ub_ff[0]   <= ub_in;
      nlow_ff[0] <= {ua_in[10:0], 20'h0};
      rem_ff[0]  <= ua_in >> 11;
      q_ff[0]    <= '0;
      neg_ff[0]  <= num[31] != den[31];
      big_ff[0]  <= {12'h0, ua_in, 20'h0} >= {1'b0, ub_in, 31'h0};
   end

   for (genvar k = 0; k < 31; k++) begin : g_step
      logic [32:0] trial;
      logic [32:0] diff;
      always_comb begin
         trial = {rem_ff[k], nlow_ff[k][30-k]};
         diff  = trial - {1'b0, ub_ff[k]};
      end
      always_ff @(posedge clock) begin
         ub_ff[k+1]   <= ub_ff[k];
         nlow_ff[k+1] <= nlow_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         big_ff[k+1]  <= big_ff[k];
         if (trial >= {1'b0, ub_ff[k]}) begin
            rem_ff[k+1] <= diff[31:0];
            q_ff[k+1]   <= {q_ff[k][29:0], 1'b1};
         end else begin
            rem_ff[k+1] <= trial[31:0];
            q_ff[k+1]   <= {q_ff[k][29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (big_ff[31]) begin
         quo_ff <= neg_ff[31] ? FIX_MIN : FIX_MAX;
      end else begin
         quo_ff <= neg_ff[31] ? -fix_type'({1'b0, q_ff[31]}) : fix_type'({1'b0, q_ff[31]});
      end
   end

   assign quo = quo_ff;
endmodule

/* rtl/jbs3_sqrt.sv */
// Pipelined length of a four-component vector, one root bit per stage.
`timescale 1ns / 1ps
module jbs3_sqrt import jbs3_pkg::*; (
   input  logic    clock,
   input  fix_type va,
   input  fix_type vb,
   input  fix_type vc,
   input  fix_type vd,
   output fix_type len
);
   logic [63:0] sq_ff   [0:3];
   logic [65:0] n_ff    [0:33];
   logic [34:0] rem_ff  [0:33];
   logic [32:0] root_ff [0:33];
   fix_type     len_ff;

   always_ff @(posedge clock) begin
      sq_ff[0] <= 64'(mag(va)) * 64'(mag(va));
      sq_ff[1] <= 64'(mag(vb)) * 64'(mag(vb));
      sq_ff[2] <= 64'(mag(vc)) * 64'(mag(vc));
      sq_ff[3] <= 64'(mag(vd)) * 64'(mag(vd));
      n_ff[0]    <= 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]) + 66'(sq_ff[3]);
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   for (genvar k = 0; k < 33; k++) begin : g_step
      logic [36:0] trial;
      logic [36:0] sub;
      always_comb begin
         trial = {rem_ff[k], n_ff[k][65-2*k -: 2]};
         sub   = {2'b00, root_ff[k], 2'b01};
      end
      always_ff @(posedge clock) begin
         n_ff[k+1] <= n_ff[k];
         if (trial >= sub) begin
            rem_ff[k+1]  <= 35'(trial - sub);
            root_ff[k+1] <= {root_ff[k][31:0], 1'b1};
         end else begin
            rem_ff[k+1]  <= trial[34:0];
            root_ff[k+1] <= {root_ff[k][31:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= (root_ff[33] > 33'(FIX_MAX)) ? FIX_MAX : fix_type'(root_ff[33][31:0]);
   end

   assign len = len_ff;
endmodule

/* rtl/julia_bulb_sym3_iteration_step_core.sv */
// Top level of the bulb iteration core: registers, pipeline stages and long units.
//
// A caller raises start with a point and its side values on the req_ ports; the
// item is taken at a clock edge where start is high and busy is low. Busy stays
// low: the pipeline takes a new item in every cycle.
// Each item gives one result on the rsp_ ports, marked by rsp_valid for exactly
// one cycle. Results leave in the order items came in. The receiver cannot hold
// results off and none is needed: the pipeline never stops.
// The pipeline holds three 31-bit dividers and five vector length units in
// series, plus 24 short stages of multiplies, adds and compares.
// Settings are written on the csr_ port, which is always ready; write them only
// while no item is in flight. Synchronous reset drops all items in flight and
// restores the register defaults.
`timescale 1ns / 1ps
module julia_bulb_sym3_iteration_step_core import jbs3_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  fix_type             req_point_x,
   input  fix_type             req_point_y,
   input  fix_type             req_point_z,
   input  fix_type             req_point_w,
   input  fix_type             req_pixel_x,
   input  fix_type             req_pixel_y,
   input  fix_type             req_pixel_z,
   input  logic [DeWidth-1:0]  req_dist_estimate,
   input  logic [RadWidth-1:0] req_radius,
   input  logic [7:0]          req_iteration,
   output logic                rsp_valid,
   output fix_type             rsp_new_x,
   output fix_type             rsp_new_y,
   output fix_type             rsp_new_z,
   output fix_type             rsp_new_w,
   output logic [DeWidth-1:0]  rsp_new_dist_estimate,
   output logic [RadWidth-1:0] rsp_new_radius,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [62:0]         csr_data
);
   localparam int IW = $bits(item_type);

   fix_type cts_ff, ysc_ff, psc_ff, sof_ff, s0sq_ff;
   logic [5:0]  mode_ff;
   logic [15:0] win_ff;
   logic [62:0] addk_ff, pixm_ff;
   fix_type k0, k1, k2, m0, m1, m2;

   item_type r0_ff, r1_ff, r2_ff, r3_ff, r4_ff, r5_ff, r6_ff, r7_ff, r8_ff;
   item_type r9_ff, r10_ff, r11_ff, r12_ff, r13_ff, r14_ff, r15_ff, r16_ff;
   item_type r17_ff, r18_ff, r19_ff, r20_ff, r21_ff, r22_ff, r23_ff;
   item_type r0_in, r1_in, r2_in, r3_in, r4_in, r5_in, r6_in, r7_in, r8_in;
   item_type r9_in, r10_in, r11_in, r12_in, r13_in, r14_in, r15_in, r16_in;
   item_type r17_in, r18_in, r19_in, r20_in, r21_in, r22_in, r23_in;
   logic [23:0] v_ff;
   logic [23:0] v_in;

   item_type u1, u2, u3, u4, u5, u6, u7, u8;
   logic [IW-1:0] d1, d2, d3, d4, d5, d6, d7, d8;
   logic uv1, uv2, uv3, uv4, uv5, uv6, uv7, uv8;
   fix_type q1, l2, l3, q4, l5, l6, l7, q8;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cts_ff  <= '0;
         ysc_ff  <= FIX_ONE;
         psc_ff  <= FIX_ONE;
         sof_ff  <= '0;
         mode_ff <= '0;
         win_ff  <= 16'hFF00;
         addk_ff <= '0;
         pixm_ff <= '0;
         s0sq_ff <= '0;
      end else begin
         s0sq_ff <= fmul(cts_ff, cts_ff);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CROSS_SCALE: cts_ff  <= fix_type'(csr_data[31:0]);
               REG_Y_SCALE:     ysc_ff  <= fix_type'(csr_data[31:0]);
               REG_POST_SCALE:  psc_ff  <= fix_type'(csr_data[31:0]);
               REG_SPHERE_OFF:  sof_ff  <= fix_type'(csr_data[31:0]);
               REG_MODE:        mode_ff <= csr_data[5:0];
               REG_FOLD_WINDOW: win_ff  <= csr_data[15:0];
               REG_ADD_CONST:   addk_ff <= csr_data;
               REG_PIXEL_MULT:  pixm_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      k0 = q16_to_fix(addk_ff[20:0]);
      k1 = q16_to_fix(addk_ff[41:21]);
      k2 = q16_to_fix(addk_ff[62:42]);
      m0 = q16_to_fix(pixm_ff[20:0]);
      m1 = q16_to_fix(pixm_ff[41:21]);
      m2 = q16_to_fix(pixm_ff[62:42]);
   end

   always_comb begin
      r0_in = '0;
      r0_in.x = req_point_x;
      r0_in.y = req_point_y;
      r0_in.z = req_point_z;
      r0_in.w = req_point_w;
      r0_in.cx = req_pixel_x;
      r0_in.cy = req_pixel_y;
      r0_in.cz = req_pixel_z;
      r0_in.de = req_dist_estimate;
      r0_in.rad = req_radius;
      r0_in.it = req_iteration;

      r1_in = r0_ff;
      r1_in.pa = 64'(TAN_PI8_Q32) * 64'(mag(r0_ff.y));
      r1_in.pb = 64'(TAN_PI8_Q32) * 64'(mag(r0_ff.z));
      r1_in.dh = 56'(r0_ff.de[47:24]) * 56'(r0_ff.rad);
      r1_in.dl = 56'(r0_ff.de[23:0]) * 56'(r0_ff.rad);

      r2_in = r1_ff;
      r2_in.sec = sector_of(r1_ff.y, r1_ff.z, r1_ff.pa, r1_ff.pb);
      r2_in.de = de_fin(r1_ff.dh, r1_ff.dl, FracBits - 1);

      r3_in = r2_ff;
      r3_in.a = fmul(r2_ff.y, cos_of(r2_ff.sec));
      r3_in.b = fmul(r2_ff.z, sin_of(r2_ff.sec));
      r3_in.c = fmul(r2_ff.y, sin_of(r2_ff.sec));
      r3_in.d = fmul(r2_ff.z, cos_of(r2_ff.sec));

      r4_in = r3_ff;
      r4_in.y = sat_sub(r3_ff.a, r3_ff.b);
      r4_in.z = sat_add(r3_ff.c, r3_ff.d);

      r5_in = r4_ff;
      r5_in.a = fmul(r4_ff.x, r4_ff.x);
      r5_in.b = fmul(r4_ff.y, r4_ff.y);
      r5_in.c = fmul(r4_ff.z, r4_ff.z);
      r5_in.d = fmul(r4_ff.x, r4_ff.y);

      r6_in = r5_ff;
      r6_in.e = fmul(r5_ff.b, r5_ff.c);
      r6_in.f = sat_add(r5_ff.a, r5_ff.b);

      r7_in = r6_ff;
      r7_in.e = fmul(s0sq_ff, r6_ff.e);
      r7_in.f = sat_add(r6_ff.f, r6_ff.c);

      r8_in = r7_ff;
      r8_in.f = sat_add(r7_ff.f, r7_ff.e);

      u1 = item_type'(d1);
      u1.e = q1;

      r9_in = u1;
      r9_in.e = sat_sub(FIX_ONE, u1.e);
      r9_in.f = sat_sub(u1.a, u1.b);
      r9_in.d = sat_dbl(u1.d);

      r10_in = r9_ff;
      r10_in.a = fmul(r9_ff.f, r9_ff.e);
      r10_in.d = fmul(r9_ff.d, r9_ff.e);

      r11_in = r10_ff;
      r11_in.d = fmul(r10_ff.d, ysc_ff);

      u2 = item_type'(d2);
      u2.f = l2;

      r12_in = u2;
      r12_in.x = u2.a;
      r12_in.c = fmul(sat_dbl(u2.z), u2.f);

      r13_in = r12_ff;
      r13_in.a = fmul(r12_ff.d, cos_of(r12_ff.sec));
      r13_in.b = fmul(r12_ff.c, sin_of(r12_ff.sec));
      r13_in.e = fmul(r12_ff.c, cos_of(r12_ff.sec));
      r13_in.f = fmul(r12_ff.d, sin_of(r12_ff.sec));

      r14_in = r13_ff;
      r14_in.x = sat_add(r13_ff.x, k0);
      r14_in.y = sat_add(sat_add(r13_ff.a, r13_ff.b), k1);
      r14_in.z = sat_add(sat_sub(r13_ff.e, r13_ff.f), k2);
      if (mode_ff[MODE_ABS_X]) r14_in.cx = abs_sat(r13_ff.cx);
      if (mode_ff[MODE_ABS_Y]) r14_in.cy = abs_sat(r13_ff.cy);
      if (mode_ff[MODE_ABS_Z]) r14_in.cz = abs_sat(r13_ff.cz);

      r15_in = r14_ff;
      r15_in.cx = fmul(r14_ff.cx, m0);
      r15_in.cy = fmul(r14_ff.cy, m1);
      r15_in.cz = fmul(r14_ff.cz, m2);

      r16_in = r15_ff;
      if (mode_ff[MODE_PIXEL]) begin
         r16_in.x = sat_add(r15_ff.x, sign_offset(r15_ff.x, r15_ff.cx));
         r16_in.y = sat_add(r15_ff.y, sign_offset(r15_ff.y, r15_ff.cy));
         r16_in.z = sat_add(r15_ff.z, sign_offset(r15_ff.z, r15_ff.cz));
      end

      u3 = item_type'(d3);
      u3.f = l3;
      u4 = item_type'(d4);
      u4.e = q4;

      r17_in = u4;
      r17_in.e = sat_sub(FIX_ONE, u4.e);
      r17_in.dh = 56'(u4.de[47:24]) * 56'(mag(psc_ff));
      r17_in.dl = 56'(u4.de[23:0]) * 56'(mag(psc_ff));

      r18_in = r17_ff;
      r18_in.x = fmul(r17_ff.x, r17_ff.e);
      r18_in.y = fmul(r17_ff.y, r17_ff.e);
      r18_in.z = fmul(r17_ff.z, r17_ff.e);
      r18_in.w = fmul(r17_ff.w, r17_ff.e);
      r18_in.de = de_fin(r17_ff.dh, r17_ff.dl, FracBits);

      r19_in = r18_ff;
      r19_in.x = fmul(r18_ff.x, psc_ff);
      r19_in.y = fmul(r18_ff.y, psc_ff);
      r19_in.z = fmul(r18_ff.z, psc_ff);
      r19_in.w = fmul(r18_ff.w, psc_ff);
      r19_in.fold = mode_ff[MODE_FOLD] && (r18_ff.it >= win_ff[7:0])
                    && (r18_ff.it < win_ff[15:8]);

      u5 = item_type'(d5);
      u5.f = l5;

      r20_in = u5;
      if (u5.fold) r20_in.rad = u5.f[RadWidth-1:0];
      r20_in.dh = 56'(u5.de[47:24]) * 56'(u5.f[RadWidth-1:0]);
      r20_in.dl = 56'(u5.de[23:0]) * 56'(u5.f[RadWidth-1:0]);
      r20_in.a = fmul(u5.x, u5.x);
      r20_in.b = fmul(u5.y, u5.y);
      r20_in.c = fmul(u5.z, u5.z);
      r20_in.d = fmul(u5.x, u5.y);
      r20_in.e = fmul(u5.x, u5.z);

      r21_in = r20_ff;
      if (r20_ff.fold) r21_in.de = de_fin(r20_ff.dh, r20_ff.dl, FracBits - 1);
      r21_in.a = sat_sub(sat_sub(r20_ff.a, r20_ff.b), r20_ff.c);
      r21_in.b = sat_dbl(r20_ff.d);
      r21_in.c = sat_dbl(r20_ff.e);

      u6 = item_type'(d6);
      u6.f = l6;
      u7 = item_type'(d7);
      u7.d = l7;
      u8 = item_type'(d8);
      u8.e = q8;

      r22_in = u8;
      r22_in.dh = 56'(u8.de[47:24]) * 56'(mag(u8.e));
      r22_in.dl = 56'(u8.de[23:0]) * 56'(mag(u8.e));

      r23_in = r22_ff;
      if (r22_ff.fold) begin
         r23_in.x = r22_ff.a;
         r23_in.y = r22_ff.b;
         r23_in.z = r22_ff.c;
         if (mode_ff[MODE_ANALYTIC]) r23_in.de = de_fin(r22_ff.dh, r22_ff.dl, FracBits);
      end
   end

   always_comb begin
      v_in = {v_ff[22], uv8, v_ff[20], uv5, v_ff[18:17], uv4, v_ff[15:12], uv2,
              v_ff[10:9], uv1, v_ff[7:0], start && !busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      r0_ff <= r0_in;   r1_ff <= r1_in;   r2_ff <= r2_in;   r3_ff <= r3_in;
      r4_ff <= r4_in;   r5_ff <= r5_in;   r6_ff <= r6_in;   r7_ff <= r7_in;
      r8_ff <= r8_in;   r9_ff <= r9_in;   r10_ff <= r10_in; r11_ff <= r11_in;
      r12_ff <= r12_in; r13_ff <= r13_in; r14_ff <= r14_in; r15_ff <= r15_in;
      r16_ff <= r16_in; r17_ff <= r17_in; r18_ff <= r18_in; r19_ff <= r19_in;
      r20_ff <= r20_in; r21_ff <= r21_in; r22_ff <= r22_in; r23_ff <= r23_in;
   end

   jbs3_div u_div1 (.clock(clock), .num(r8_ff.c), .den(r8_ff.f), .quo(q1));
   jbs3_delay #(.W(IW), .DEPTH(DIV_LAT)) u_dly1 (
      .clock(clock), .reset(reset), .in_valid(v_ff[8]), .in_data(r8_ff),
      .out_valid(uv1), .out_data(d1));

   jbs3_sqrt u_sqrt1 (.clock(clock), .va(r11_ff.x), .vb(r11_ff.y), .vc('0), .vd('0),
                      .len(l2));
   jbs3_delay #(.W(IW), .DEPTH(SQRT_LAT)) u_dly2 (
      .clock(clock), .reset(reset), .in_valid(v_ff[11]), .in_data(r11_ff),
      .out_valid(uv2), .out_data(d2));

   jbs3_sqrt u_sqrt2 (.clock(clock), .va(r16_ff.x), .vb(r16_ff.y), .vc(r16_ff.z),
                      .vd(r16_ff.w), .len(l3));
   jbs3_delay #(.W(IW), .DEPTH(SQRT_LAT)) u_dly3 (
      .clock(clock), .reset(reset), .in_valid(v_ff[16]), .in_data(r16_ff),
      .out_valid(uv3), .out_data(d3));

   jbs3_div u_div2 (.clock(clock), .num(sof_ff), .den(u3.f), .quo(q4));
   jbs3_delay #(.W(IW), .DEPTH(DIV_LAT)) u_dly4 (
      .clock(clock), .reset(reset), .in_valid(uv3), .in_data(u3),
      .out_valid(uv4), .out_data(d4));

   jbs3_sqrt u_sqrt3 (.clock(clock), .va(r19_ff.x), .vb(r19_ff.y), .vc(r19_ff.z),
                      .vd(r19_ff.w), .len(l5));
   jbs3_delay #(.W(IW), .DEPTH(SQRT_LAT)) u_dly5 (
      .clock(clock), .reset(reset), .in_valid(v_ff[19]), .in_data(r19_ff),
      .out_valid(uv5), .out_data(d5));

   jbs3_sqrt u_sqrt4 (.clock(clock), .va(r21_ff.a), .vb(r21_ff.d), .vc(r21_ff.e),
                      .vd(r21_ff.w), .len(l6));
   jbs3_delay #(.W(IW), .DEPTH(SQRT_LAT)) u_dly6 (
      .clock(clock), .reset(reset), .in_valid(v_ff[21]), .in_data(r21_ff),
      .out_valid(uv6), .out_data(d6));

   jbs3_sqrt u_sqrt5 (.clock(clock), .va(u6.a), .vb(u6.b), .vc(u6.c), .vd(u6.w),
                      .len(l7));
   jbs3_delay #(.W(IW), .DEPTH(SQRT_LAT)) u_dly7 (
      .clock(clock), .reset(reset), .in_valid(uv6), .in_data(u6),
      .out_valid(uv7), .out_data(d7));

   jbs3_div u_div3 (.clock(clock), .num(u7.d), .den(u7.f), .quo(q8));
   jbs3_delay #(.W(IW), .DEPTH(DIV_LAT)) u_dly8 (
      .clock(clock), .reset(reset), .in_valid(uv7), .in_data(u7),
      .out_valid(uv8), .out_data(d8));

   assign rsp_valid             = v_ff[23];
   assign rsp_new_x             = r23_ff.x;
   assign rsp_new_y             = r23_ff.y;
   assign rsp_new_z             = r23_ff.z;
   assign rsp_new_w             = r23_ff.w;
   assign rsp_new_dist_estimate = r23_ff.de;
   assign rsp_new_radius        = r23_ff.rad;
endmodule

/* rtl/jbs3_checker.sv */
// Port-level checks of the bulb iteration core and their binding to the top level.
`timescale 1ns / 1ps
module jbs3_checker import jbs3_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result strobe right after reset.");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("Result strobe without an item taken at the fixed latency.");

   a_item_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("Item taken but no result at the fixed latency.");
endmodule

bind julia_bulb_sym3_iteration_step_core jbs3_checker u_jbs3_checker (.*);
